>>> rtl/fgac_pkg.sv
// Shared types, constants and the two-byte offset function of the glyph address calculator.
`timescale 1ns / 1ps
`default_nettype none

package fgac_pkg;

   localparam int ADDR_W    = 32;
   localparam int BASE_W    = 24;
   localparam int CSR_COUNT = 8;
   localparam int CSR_IDX_W = $clog2(CSR_COUNT);
   localparam int STRIDE_W  = 8;
   localparam int WIDTH_W   = 3;
   localparam int ROW_W     = 6;
   localparam int GB2_OFF_W = 16;

   typedef enum logic [1:0] {
      KIND_SPACE = 2'd0,
      KIND_ASCII = 2'd1,
      KIND_GB2   = 2'd2,
      KIND_GB4   = 2'd3
   } char_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ASCII_BASE_12 = 3'd0,
      CSR_ASCII_BASE_16 = 3'd1,
      CSR_ASCII_BASE_24 = 3'd2,
      CSR_ASCII_BASE_32 = 3'd3,
      CSR_HANZI_BASE_16 = 3'd4,
      CSR_HANZI_BASE_24 = 3'd5,
      CSR_HANZI_BASE_32 = 3'd6,
      CSR_NULL_ADDRESS  = 3'd7
   } csr_index_type;

   localparam logic [7:0] SIZE_12 = 8'd12;
   localparam logic [7:0] SIZE_16 = 8'd16;
   localparam logic [7:0] SIZE_24 = 8'd24;
   localparam logic [7:0] SIZE_32 = 8'd32;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] ASCII_LOW  = 8'h21;
   localparam logic [7:0] ASCII_HIGH = 8'h7E;

   // Offsets of the code ranges within the GB glyph table.
   localparam logic [31:0] GB_SYMBOL_COUNT = 32'd1038;
   localparam logic [31:0] GB_EXT1_BASE    = 32'd6768;
   localparam logic [31:0] GB_EXT2_BASE    = 32'd12848;
   localparam logic [31:0] GB_SYM_EXT_BASE = 32'd846;
   localparam logic [31:0] GB4_BASE        = 32'd21008;
   localparam logic [31:0] GB4_PLANE_SKIP  = 32'd161;
   localparam logic [31:0] GB4_PLANE_SIZE  = 32'd1260;
   localparam logic [31:0] CUT_OFFSET      = 32'd192;

   typedef struct packed {
      logic                 ok;
      logic [GB2_OFF_W-1:0] off;
   } gb2_type;

   function automatic logic in_range(input logic [7:0] v, input logic [7:0] lo,
                                     input logic [7:0] hi);
      return (v >= lo) && (v <= hi);
   endfunction

   // Glyph offset of a two-byte code; ranges are tried in priority order.
   function automatic gb2_type gb2_offset(input logic [7:0] a, input logic [7:0] b);
      gb2_type              res;
      logic [GB2_OFF_W-1:0] aw;
      logic [GB2_OFF_W-1:0] bw;
      aw      = {8'd0, a};
      bw      = {8'd0, b};
      res.ok  = 1'b1;
      res.off = '0;
      if (in_range(a, 8'hA1, 8'hA9) && in_range(b, 8'hA1, 8'hFE)) begin
         res.off = (aw - 16'hA1) * 16'd94 + (bw - 16'hA1);
      end else if (in_range(a, 8'hA8, 8'hA9) && in_range(b, 8'h40, 8'h7E)) begin
         res.off = (aw - 16'hA8) * 16'd96 + (bw - 16'h40) + GB_SYM_EXT_BASE[15:0];
      end else if (in_range(a, 8'hA8, 8'hA9) && in_range(b, 8'h80, 8'hA0)) begin
         res.off = (aw - 16'hA8) * 16'd96 + (bw - 16'h41) + GB_SYM_EXT_BASE[15:0];
      end else if (in_range(a, 8'hB0, 8'hF7) && in_range(b, 8'hA1, 8'hFE)) begin
         res.off = (aw - 16'hB0) * 16'd94 + (bw - 16'hA1) + GB_SYMBOL_COUNT[15:0];
      end else if (in_range(a, 8'h81, 8'hA0) && in_range(b, 8'h40, 8'h7E)) begin
         res.off = (aw - 16'h81) * 16'd190 + (bw - 16'h40) + GB_SYMBOL_COUNT[15:0]
                   + GB_EXT1_BASE[15:0];
      end else if (in_range(a, 8'h81, 8'hA0) && in_range(b, 8'h80, 8'hFE)) begin
         res.off = (aw - 16'h81) * 16'd190 + (bw - 16'h41) + GB_SYMBOL_COUNT[15:0]
                   + GB_EXT1_BASE[15:0];
      end else if (in_range(a, 8'hAA, 8'hFE) && in_range(b, 8'h40, 8'h7E)) begin
         res.off = (aw - 16'hAA) * 16'd96 + (bw - 16'h40) + GB_SYMBOL_COUNT[15:0]
                   + GB_EXT2_BASE[15:0];
      end else if (in_range(a, 8'hAA, 8'hFE) && in_range(b, 8'h80, 8'hA0)) begin
         res.off = (aw - 16'hAA) * 16'd96 + (bw - 16'h41) + GB_SYMBOL_COUNT[15:0]
                   + GB_EXT2_BASE[15:0];
      end else begin
         res.ok = 1'b0;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

>>> rtl/font_glyph_address_calc.sv
// Top level of the font glyph address calculator: decode stage and address stage.
// A request is held in the decode registers, then the result registers. Throughput: one
// transaction per cycle while not stalled; the first stage decodes the character and
// the glyph offset, the second forms offset * stride + base + row * row width.
// Reset clears the eight base registers to zero and empties both stages.
// The request side stalls only when both stages hold data and the result is stalled.
`timescale 1ns / 1ps
`default_nettype none

module font_glyph_address_calc (
   input  wire logic                                clock,
   input  wire logic                                reset,

   input  wire logic                                csr_write,
   input  wire logic [fgac_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [fgac_pkg::BASE_W-1:0]         csr_wdata,

   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire logic [7:0]                          req_first_byte,
   input  wire logic [7:0]                          req_second_byte,
   input  wire logic [7:0]                          req_third_byte,
   input  wire logic [7:0]                          req_fourth_byte,
   input  wire logic [7:0]                          req_font_size,
   input  wire logic [fgac_pkg::ROW_W-1:0]          req_glyph_row,

   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      logic [fgac_pkg::ADDR_W-1:0]         rsp_rom_address,
   output      logic [1:0]                          rsp_char_kind,
   output      logic [2:0]                          rsp_bytes_used,
   output      logic                                rsp_code_valid
);

   import fgac_pkg::*;

   logic [BASE_W-1:0] base_ff [CSR_COUNT];

   // Decode stage.
   logic                  pipe_valid_ff, pipe_valid_in;
   logic [ADDR_W-1:0]     off_ff, off_in;
   logic [STRIDE_W-1:0]   stride_ff, stride_in;
   logic [WIDTH_W-1:0]    width_ff, width_in;
   csr_index_type         base_sel_ff, base_sel_in;
   logic                  zero_base_ff, zero_base_in;
   logic [ROW_W-1:0]      row_ff;
   char_kind_type         kind_ff, kind_in;
   logic [2:0]            used_ff, used_in;
   logic                  code_ok_ff, code_ok_in;

   // Result stage.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]     addr_ff, addr_in;
   char_kind_type         rsp_kind_ff;
   logic [2:0]            rsp_used_ff;
   logic                  rsp_ok_ff;

   logic                  adv_out;
   logic                  accept;

   assign adv_out   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = pipe_valid_ff && !adv_out;
   assign accept    = req_valid && !req_stall;

   assign pipe_valid_in = accept || (pipe_valid_ff && !adv_out);
   assign rsp_valid_in  = adv_out ? pipe_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < CSR_COUNT; i++) begin
            base_ff[i] <= '0;
         end
      end else begin
         pipe_valid_ff <= pipe_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_write) begin
            base_ff[csr_index] <= csr_wdata;
         end
      end
   end

   // Character decode and glyph offset.
   always_comb begin
      gb2_type           gb2;
      logic [ADDR_W-1:0] raw_off;
      logic              is_gb;
      logic              cut;
      logic [ADDR_W-1:0] b2;
      logic [ADDR_W-1:0] b3;
      logic [ADDR_W-1:0] b4;
      b2           = {24'd0, req_second_byte};
      b3           = {24'd0, req_third_byte};
      b4           = {24'd0, req_fourth_byte};
      gb2          = gb2_offset(req_first_byte, req_second_byte);
      raw_off      = '0;
      is_gb        = 1'b0;
      cut          = 1'b0;
      code_ok_in   = 1'b1;
      stride_in    = '0;
      width_in     = '0;
      base_sel_in  = CSR_NULL_ADDRESS;
      zero_base_in = 1'b0;

      if (req_first_byte == CHAR_SPACE) begin
         kind_in      = KIND_SPACE;
         used_in      = 3'd1;
         zero_base_in = 1'b1;
      end else if (in_range(req_first_byte, ASCII_LOW, ASCII_HIGH)) begin
         kind_in = KIND_ASCII;
         used_in = 3'd1;
         raw_off = {24'd0, req_first_byte - ASCII_LOW};
         case (req_font_size)
            SIZE_12: begin
               stride_in   = 8'd28;
               width_in    = 3'd2;
               base_sel_in = CSR_ASCII_BASE_12;
            end
            SIZE_16: begin
               stride_in   = 8'd36;
               width_in    = 3'd2;
               base_sel_in = CSR_ASCII_BASE_16;
            end
            SIZE_24: begin
               stride_in   = 8'd78;
               width_in    = 3'd3;
               base_sel_in = CSR_ASCII_BASE_24;
            end
            SIZE_32: begin
               stride_in   = 8'd136;
               width_in    = 3'd4;
               base_sel_in = CSR_ASCII_BASE_32;
            end
            default: begin
               base_sel_in = CSR_NULL_ADDRESS;
            end
         endcase
      end else if (in_range(req_first_byte, 8'h81, 8'h82)
                   && in_range(req_second_byte, 8'h30, 8'h39)) begin
         kind_in = KIND_GB4;
         used_in = 3'd4;
         is_gb   = 1'b1;
         cut     = 1'b1;
         // The third and fourth bytes are not range checked, so these terms may wrap.
         if (req_first_byte == 8'h81) begin
            raw_off = GB_SYMBOL_COUNT + GB4_BASE + (b3 - 32'hEE) * 32'd10
                      + b4 - 32'h39;
         end else begin
            raw_off = GB_SYMBOL_COUNT + GB4_BASE + GB4_PLANE_SKIP
                      + (b2 - 32'h30) * GB4_PLANE_SIZE
                      + (b3 - 32'h81) * 32'd10 + b4 - 32'h30;
         end
      end else begin
         kind_in    = KIND_GB2;
         used_in    = 3'd2;
         is_gb      = 1'b1;
         code_ok_in = gb2.ok;
         raw_off    = {16'd0, gb2.off};
         cut        = !in_range(req_first_byte, 8'hA1, 8'hA9);
      end

      off_in = raw_off;
      if (is_gb) begin
         case (req_font_size)
            SIZE_16: begin
               stride_in   = 8'd32;
               width_in    = 3'd2;
               base_sel_in = CSR_HANZI_BASE_16;
            end
            SIZE_24: begin
               stride_in   = 8'd72;
               width_in    = 3'd3;
               base_sel_in = CSR_HANZI_BASE_24;
            end
            SIZE_32: begin
               stride_in   = 8'd128;
               width_in    = 3'd4;
               base_sel_in = CSR_HANZI_BASE_32;
               // Non-symbol codes skip the symbol block in the 32-pixel table.
               if (cut) begin
                  off_in = raw_off - CUT_OFFSET;
               end
            end
            default: begin
               base_sel_in = CSR_NULL_ADDRESS;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         off_ff       <= off_in;
         stride_ff    <= stride_in;
         width_ff     <= width_in;
         base_sel_ff  <= base_sel_in;
         zero_base_ff <= zero_base_in;
         row_ff       <= req_glyph_row;
         kind_ff      <= kind_in;
         used_ff      <= used_in;
         code_ok_ff   <= code_ok_in;
      end
   end

   // Address: an unsupported size has zero stride and width, leaving the null address.
   always_comb begin
      logic [ADDR_W-1:0] product;
      logic [ADDR_W-1:0] base;
      logic [8:0]        row_prod;
      logic [ADDR_W-1:0] row_term;
      product  = off_ff * {24'd0, stride_ff};
      base     = zero_base_ff ? '0 : {8'd0, base_ff[base_sel_ff]};
      row_prod = {3'd0, row_ff} * {6'd0, width_ff};
      row_term = {23'd0, row_prod};
      addr_in  = product + base + row_term;
   end

   always_ff @(posedge clock) begin
      if (adv_out && pipe_valid_ff) begin
         addr_ff     <= addr_in;
         rsp_kind_ff <= kind_ff;
         rsp_used_ff <= used_ff;
         rsp_ok_ff   <= code_ok_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_rom_address = addr_ff;
   assign rsp_char_kind   = rsp_kind_ff;
   assign rsp_bytes_used  = rsp_used_ff;
   assign rsp_code_valid  = rsp_ok_ff;

   a_space_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == KIND_SPACE) |-> (addr_ff == '0 && rsp_ok_ff))
      else $error("space transaction produced a nonzero address or invalid code");

   a_used_kind : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_kind_ff == KIND_SPACE && rsp_used_ff == 3'd1)
                        || (rsp_kind_ff == KIND_ASCII && rsp_used_ff == 3'd1)
                        || (rsp_kind_ff == KIND_GB2 && rsp_used_ff == 3'd2)
                        || (rsp_kind_ff == KIND_GB4 && rsp_used_ff == 3'd4)))
      else $error("bytes used does not match character kind");

   a_invalid_only_gb2 : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ok_ff) |-> (rsp_kind_ff == KIND_GB2))
      else $error("invalid code reported for a kind other than two-byte");

   a_stall_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (pipe_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("request stalled while the pipeline had room");

   a_result_follows : assert property (@(posedge clock) disable iff (reset)
      (pipe_valid_ff && adv_out) |=> rsp_valid_ff)
      else $error("decoded transaction was lost between stages");

endmodule

`default_nettype wire

>>> tb/sv/glyph_check_pkg.sv
// Scoreboard that predicts and checks glyph row addresses of the font ROM address calculator.
`timescale 1ns / 1ps

package glyph_check_pkg;

   import fgac_pkg::*;

   // Glyph counts that place each code range within the GB glyph table.
   localparam bit [31:0] GLYPHS_SYM_EXT    = 32'd846;
   localparam bit [31:0] GLYPHS_SYMBOLS    = 32'd1038;
   localparam bit [31:0] GLYPHS_EXT1       = 32'd6768;
   localparam bit [31:0] GLYPHS_EXT2       = 32'd12848;
   localparam bit [31:0] GLYPHS_GB4        = 32'd21008;
   localparam bit [31:0] GB4_PLANE2_SKIP   = 32'd161;
   localparam bit [31:0] GB4_PLANE_GLYPHS  = 32'd1260;
   localparam bit [31:0] SIZE32_CUT        = 32'd192;

   typedef struct {
      logic [31:0]   rom_address;
      char_kind_type char_kind;
      logic [2:0]    bytes_used;
      logic          code_valid;
   } glyph_row_result;

   class glyph_addr_scoreboard;

      bit [BASE_W-1:0] base_reg [CSR_COUNT];
      glyph_row_result pending_q [$];
      int unsigned     fail_count;

      function new();
         foreach (base_reg[i]) base_reg[i] = '0;
         fail_count = 0;
      endfunction

      function void set_base(csr_index_type idx, bit [BASE_W-1:0] value);
         base_reg[idx] = value;
      endfunction

      function bit between(bit [7:0] v, bit [7:0] lo, bit [7:0] hi);
         return (v >= lo) && (v <= hi);
      endfunction

      // Two-byte code ranges, tried in priority order; no match gives glyph zero.
      function bit [31:0] gb2_glyph_offset(bit [7:0] a, bit [7:0] b, output bit matched);
         bit [31:0] aw;
         bit [31:0] bw;
         aw      = {24'd0, a};
         bw      = {24'd0, b};
         matched = 1'b1;
         if (between(a, 8'hA1, 8'hA9) && between(b, 8'hA1, 8'hFE))
            return (aw - 32'hA1) * 32'd94 + (bw - 32'hA1);
         if (between(a, 8'hA8, 8'hA9) && between(b, 8'h40, 8'h7E))
            return (aw - 32'hA8) * 32'd96 + (bw - 32'h40) + GLYPHS_SYM_EXT;
         if (between(a, 8'hA8, 8'hA9) && between(b, 8'h80, 8'hA0))
            return (aw - 32'hA8) * 32'd96 + (bw - 32'h41) + GLYPHS_SYM_EXT;
         if (between(a, 8'hB0, 8'hF7) && between(b, 8'hA1, 8'hFE))
            return (aw - 32'hB0) * 32'd94 + (bw - 32'hA1) + GLYPHS_SYMBOLS;
         if (between(a, 8'h81, 8'hA0) && between(b, 8'h40, 8'h7E))
            return (aw - 32'h81) * 32'd190 + (bw - 32'h40) + GLYPHS_SYMBOLS + GLYPHS_EXT1;
         if (between(a, 8'h81, 8'hA0) && between(b, 8'h80, 8'hFE))
            return (aw - 32'h81) * 32'd190 + (bw - 32'h41) + GLYPHS_SYMBOLS + GLYPHS_EXT1;
         if (between(a, 8'hAA, 8'hFE) && between(b, 8'h40, 8'h7E))
            return (aw - 32'hAA) * 32'd96 + (bw - 32'h40) + GLYPHS_SYMBOLS + GLYPHS_EXT2;
         if (between(a, 8'hAA, 8'hFE) && between(b, 8'h80, 8'hA0))
            return (aw - 32'hAA) * 32'd96 + (bw - 32'h41) + GLYPHS_SYMBOLS + GLYPHS_EXT2;
         matched = 1'b0;
         return 32'd0;
      endfunction

      function bit [31:0] gb_rom_address(bit [7:0] size, bit [31:0] glyph, bit [31:0] row,
                                         bit cut);
         bit [31:0] g;
         g = glyph;
         case (size)
            8'd16: return g * 32'd32 + base_reg[CSR_HANZI_BASE_16] + row * 32'd2;
            8'd24: return g * 32'd72 + base_reg[CSR_HANZI_BASE_24] + row * 32'd3;
            8'd32: begin
               if (cut) g = g - SIZE32_CUT;
               return g * 32'd128 + base_reg[CSR_HANZI_BASE_32] + row * 32'd4;
            end
            default: return {8'd0, base_reg[CSR_NULL_ADDRESS]};
         endcase
      endfunction

      function glyph_row_result predict(bit [7:0] c1, bit [7:0] c2, bit [7:0] c3,
                                        bit [7:0] c4, bit [7:0] size, bit [5:0] row);
         glyph_row_result res;
         bit [31:0]       glyph;
         bit [31:0]       r32;
         bit              matched;
         r32             = {26'd0, row};
         res.rom_address = '0;
         res.code_valid  = 1'b1;
         if (c1 == 8'h20) begin
            res.char_kind  = KIND_SPACE;
            res.bytes_used = 3'd1;
         end else if (between(c1, 8'h21, 8'h7E)) begin
            res.char_kind  = KIND_ASCII;
            res.bytes_used = 3'd1;
            glyph          = {24'd0, c1} - 32'h21;
            case (size)
               8'd12: res.rom_address = glyph * 32'd28 + base_reg[CSR_ASCII_BASE_12]
                                        + r32 * 32'd2;
               8'd16: res.rom_address = glyph * 32'd36 + base_reg[CSR_ASCII_BASE_16]
                                        + r32 * 32'd2;
               8'd24: res.rom_address = glyph * 32'd78 + base_reg[CSR_ASCII_BASE_24]
                                        + r32 * 32'd3;
               8'd32: res.rom_address = glyph * 32'd136 + base_reg[CSR_ASCII_BASE_32]
                                        + r32 * 32'd4;
               default: res.rom_address = {8'd0, base_reg[CSR_NULL_ADDRESS]};
            endcase
         end else if (between(c1, 8'h81, 8'h82) && between(c2, 8'h30, 8'h39)) begin
            res.char_kind  = KIND_GB4;
            res.bytes_used = 3'd4;
            // The third and fourth bytes are not range checked, so these terms may wrap.
            if (c1 == 8'h81)
               glyph = GLYPHS_SYMBOLS + GLYPHS_GB4 + ({24'd0, c3} - 32'hEE) * 32'd10
                       + {24'd0, c4} - 32'h39;
            else
               glyph = GLYPHS_SYMBOLS + GLYPHS_GB4 + GB4_PLANE2_SKIP
                       + ({24'd0, c2} - 32'h30) * GB4_PLANE_GLYPHS
                       + ({24'd0, c3} - 32'h81) * 32'd10 + {24'd0, c4} - 32'h30;
            res.rom_address = gb_rom_address(size, glyph, r32, 1'b1);
         end else begin
            res.char_kind   = KIND_GB2;
            res.bytes_used  = 3'd2;
            glyph           = gb2_glyph_offset(c1, c2, matched);
            res.code_valid  = matched;
            res.rom_address = gb_rom_address(size, glyph, r32, !between(c1, 8'hA1, 8'hA9));
         end
         return res;
      endfunction

      function void note_request(bit [7:0] c1, bit [7:0] c2, bit [7:0] c3, bit [7:0] c4,
                                 bit [7:0] size, bit [5:0] row);
         pending_q.push_back(predict(c1, c2, c3, c4, size, row));
      endfunction

      function void check_response(logic [31:0] addr, logic [1:0] kind, logic [2:0] used,
                                   logic valid);
         glyph_row_result exp;
         if (pending_q.size() == 0) begin
            $error("rom_address: no transaction pending, got %h", addr);
            fail_count++;
            return;
         end
         exp = pending_q.pop_front();
         if (addr !== exp.rom_address) begin
            $error("rom_address: expected %h, got %h", exp.rom_address, addr);
            fail_count++;
         end
         if (kind !== exp.char_kind) begin
            $error("char_kind: expected %0d, got %0d", exp.char_kind, kind);
            fail_count++;
         end
         if (used !== exp.bytes_used) begin
            $error("bytes_used: expected %0d, got %0d", exp.bytes_used, used);
            fail_count++;
         end
         if (valid !== exp.code_valid) begin
            $error("code_valid: expected %0d, got %0d", exp.code_valid, valid);
            fail_count++;
         end
      endfunction

   endclass

endpackage

>>> tb/sv/font_glyph_address_calc_test.sv
// Self-checking testbench of the font glyph address calculator.
`timescale 1ns / 1ps

module font_glyph_address_calc_test;

   import fgac_pkg::*;
   import glyph_check_pkg::*;

   typedef enum int {
      PACE_RANDOM,
      PACE_FLAT_OUT,
      PACE_BACKPRESSURE
   } pace_type;

   localparam int PHASE_COUNT     = 5;
   localparam int ITEMS_PER_PHASE = 130;

   logic                 clock           = 1'b0;
   logic                 reset           = 1'b1;
   logic                 csr_write       = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index       = '0;
   logic [BASE_W-1:0]    csr_wdata       = '0;
   logic                 req_valid       = 1'b0;
   logic                 req_stall;
   logic [7:0]           req_first_byte  = '0;
   logic [7:0]           req_second_byte = '0;
   logic [7:0]           req_third_byte  = '0;
   logic [7:0]           req_fourth_byte = '0;
   logic [7:0]           req_font_size   = '0;
   logic [ROW_W-1:0]     req_glyph_row   = '0;
   logic                 rsp_valid;
   logic                 rsp_stall       = 1'b0;
   logic [ADDR_W-1:0]    rsp_rom_address;
   logic [1:0]           rsp_char_kind;
   logic [2:0]           rsp_bytes_used;
   logic                 rsp_code_valid;

   glyph_addr_scoreboard rom_sb     = new();
   pace_type             pace       = PACE_RANDOM;
   int unsigned          stall_left = 0;

   always #4 clock = ~clock;

   font_glyph_address_calc dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_first_byte  (req_first_byte),
      .req_second_byte (req_second_byte),
      .req_third_byte  (req_third_byte),
      .req_fourth_byte (req_fourth_byte),
      .req_font_size   (req_font_size),
      .req_glyph_row   (req_glyph_row),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_rom_address (rsp_rom_address),
      .rsp_char_kind   (rsp_char_kind),
      .rsp_bytes_used  (rsp_bytes_used),
      .rsp_code_valid  (rsp_code_valid)
   );

   // Mostly short gaps, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   function automatic logic [7:0] pick_size();
      if ($urandom_range(0, 99) >= 88) return 8'($urandom_range(0, 255));
      case ($urandom_range(0, 3))
         0: return SIZE_12;
         1: return SIZE_16;
         2: return SIZE_24;
         default: return SIZE_32;
      endcase
   endfunction

   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (pace != PACE_FLAT_OUT &&
                   $urandom_range(0, (pace == PACE_BACKPRESSURE) ? 2 : 7) == 0) begin
         stall_left <= pick_gap();
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         rom_sb.check_response(rsp_rom_address, rsp_char_kind, rsp_bytes_used,
                               rsp_code_valid);
   end

   task automatic send_char(input logic [7:0] c1, input logic [7:0] c2, input logic [7:0] c3,
                            input logic [7:0] c4, input logic [7:0] size,
                            input logic [ROW_W-1:0] row);
      int unsigned gap;
      req_valid       <= 1'b1;
      req_first_byte  <= c1;
      req_second_byte <= c2;
      req_third_byte  <= c3;
      req_fourth_byte <= c4;
      req_font_size   <= size;
      req_glyph_row   <= row;
      do @(posedge clock); while (req_stall);
      rom_sb.note_request(c1, c2, c3, c4, size, row);
      gap = (pace == PACE_RANDOM) ? pick_gap() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic random_char();
      logic [7:0]  c1;
      logic [7:0]  c2;
      logic [7:0]  c3;
      logic [7:0]  c4;
      int unsigned pick;
      c1   = 8'($urandom);
      c2   = 8'($urandom);
      c3   = 8'($urandom);
      c4   = 8'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         c1 = 8'h20;
      end else if (pick < 30) begin
         c1 = 8'($urandom_range(8'h21, 8'h7E));
      end else if (pick < 50) begin
         c1 = 8'($urandom_range(8'h81, 8'h82));
         c2 = 8'($urandom_range(8'h30, 8'h39));
         if ($urandom_range(0, 3) != 0) begin
            c3 = 8'($urandom_range(8'h81, 8'hFE));
            c4 = 8'($urandom_range(8'h30, 8'h39));
         end
      end else if (pick < 85) begin
         // Two-byte codes, weighted toward the symbol rows that skip the size-32 cut.
         if ($urandom_range(0, 2) == 0)
            c1 = 8'($urandom_range(8'hA1, 8'hA9));
         else
            c1 = 8'($urandom_range(8'h81, 8'hFE));
         c2 = 8'($urandom_range(8'h40, 8'hFE));
      end
      send_char(c1, c2, c3, c4, pick_size(), ROW_W'($urandom_range(0, 63)));
   endtask

   task automatic load_bases(input logic [BASE_W-1:0] vals [CSR_COUNT]);
      for (int i = 0; i < CSR_COUNT; i++) begin
         csr_write <= 1'b1;
         csr_index <= csr_index_type'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
         rom_sb.set_base(csr_index_type'(i), vals[i]);
      end
      csr_write <= 1'b0;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (rom_sb.pending_q.size() != 0) @(posedge clock);
   endtask

   initial begin
      logic [BASE_W-1:0] vals [CSR_COUNT];
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (vals[i]) vals[i] = BASE_W'($urandom);
      load_bases(vals);

      send_char(8'h20, 8'h41, 8'h00, 8'h00, SIZE_16, 6'd5);
      send_char(8'h20, 8'h00, 8'hFF, 8'hFF, 8'h00, 6'd63);
      send_char(8'h21, 8'h00, 8'h00, 8'h00, SIZE_12, 6'd0);
      send_char(8'h7E, 8'hFF, 8'hFF, 8'hFF, SIZE_32, 6'd63);
      send_char(8'h5A, 8'h20, 8'h00, 8'h00, SIZE_24, 6'd33);
      send_char(8'h7E, 8'h00, 8'h00, 8'h00, 8'hFF, 6'd1);
      // Four-byte: first code of 81, last plane of 82, wrapping tail, size 12 unsupported.
      send_char(8'h81, 8'h30, 8'hEE, 8'h39, SIZE_16, 6'd0);
      send_char(8'h82, 8'h39, 8'h81, 8'h30, SIZE_32, 6'd63);
      send_char(8'h81, 8'h30, 8'h00, 8'h00, SIZE_24, 6'd7);
      send_char(8'h82, 8'h35, 8'hFE, 8'hFF, SIZE_12, 6'd2);
      // One code at each edge of the two-byte ranges.
      send_char(8'hA1, 8'hA1, 8'h00, 8'h00, SIZE_16, 6'd0);
      send_char(8'hA9, 8'hFE, 8'h00, 8'h00, SIZE_32, 6'd31);
      send_char(8'hA8, 8'h40, 8'h00, 8'h00, SIZE_24, 6'd4);
      send_char(8'hA9, 8'hA0, 8'h00, 8'h00, SIZE_32, 6'd9);
      send_char(8'hB0, 8'hA1, 8'h00, 8'h00, SIZE_16, 6'd15);
      send_char(8'hF7, 8'hFE, 8'h00, 8'h00, SIZE_32, 6'd0);
      send_char(8'h81, 8'h40, 8'h00, 8'h00, SIZE_24, 6'd23);
      send_char(8'hA0, 8'hFE, 8'h00, 8'h00, SIZE_32, 6'd12);
      send_char(8'hAA, 8'h40, 8'h00, 8'h00, SIZE_16, 6'd1);
      send_char(8'hFE, 8'hA0, 8'h00, 8'h00, SIZE_24, 6'd2);
      // Unmatched two-byte codes, with and without the size-32 cut.
      send_char(8'hA1, 8'h40, 8'h00, 8'h00, SIZE_32, 6'd3);
      send_char(8'h7F, 8'h7F, 8'h00, 8'h00, SIZE_32, 6'd8);
      send_char(8'h00, 8'h00, 8'h00, 8'h00, SIZE_16, 6'd0);
      send_char(8'hFF, 8'hFF, 8'hFF, 8'hFF, SIZE_32, 6'd63);
      send_char(8'h81, 8'h3A, 8'h00, 8'h00, SIZE_12, 6'd10);
      drain();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         foreach (vals[i]) begin
            case (phase)
               0: vals[i] = '1;
               1: vals[i] = '0;
               default: vals[i] = BASE_W'($urandom);
            endcase
         end
         load_bases(vals);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n % 40 == 0) pace <= pace_type'($urandom_range(0, 2));
            random_char();
         end
         drain();
      end

      repeat (10) @(posedge clock);
      if (rom_sb.fail_count == 0 && rom_sb.pending_q.size() == 0) begin
         $display("[font_glyph_address_calc] OK");
      end else begin
         $display("[font_glyph_address_calc] ERROR");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("[font_glyph_address_calc] ERROR");
      $finish;
   end

endmodule
